>>> src/can_frame_receive_fifo_core_macros.svh
// Assertion macros used by the receive FIFO port checker.
`ifndef CAN_FRAME_RECEIVE_FIFO_CORE_MACROS_SVH
`define CAN_FRAME_RECEIVE_FIFO_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CFRF_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CFRF_ASSERT_RST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/cfrf_pkg.sv
// Types and constants of the CAN frame receive FIFO.
package cfrf_pkg;

	localparam int ID_W     = 29;
	localparam int LEN_W    = 4;
	localparam int DATA_W   = 64;
	localparam int PEND_W   = 8;
	localparam int ENABLE_W = 3;

	localparam logic [PEND_W-1:0] PENDING_MAX = 8'hff;
	localparam logic [LEN_W-1:0]  MAX_LEN     = 4'd8;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_DROP_FULL = 3'd1,
		ST_IGNORED   = 3'd2,
		ST_POPPED    = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
	} frame_t;

	// Outcome of one beat, as decided from the ring pointers.
	typedef struct packed {
		status_t           status;
		logic [PEND_W-1:0] pending;
		logic              full;
		logic              hit;
	} resp_t;

	// Frame memory access requested for one beat.
	typedef struct packed {
		logic we;
		logic re;
	} mem_req_t;

	// Keeps the bytes below the length and zeroes the rest.
	function automatic logic [DATA_W-1:0] data_mask(input logic [LEN_W-1:0] len);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < DATA_W / 8; b++) begin
			if (LEN_W'(b) < len) begin
				m[b*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

>>> src/cfrf_frame_ram.sv
// Frame storage memory with one write port and one registered read port.
module cfrf_frame_ram #(
	parameter int DEPTH  = 48,
	parameter int ADDR_W = 6
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  cfrf_pkg::frame_t     wdata,
	input  logic                 re,
	input  logic [ADDR_W-1:0]    raddr,
	output cfrf_pkg::frame_t     rdata
);

	cfrf_pkg::frame_t mem [DEPTH];
	cfrf_pkg::frame_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/cfrf_ring_ctrl.sv
// Per-channel ring pointers, full flags, pending counts and channel enables.
module cfrf_ring_ctrl #(
	parameter int CHANNELS   = 3,
	parameter int RING_DEPTH = 16,
	parameter int ADDR_W     = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cfrf_pkg::ENABLE_W-1:0]       cfg_wdata,
	input  logic                                accept,
	input  logic                                kind,
	input  logic [1:0]                          channel,
	input  logic [cfrf_pkg::LEN_W-1:0]          frame_length,
	output cfrf_pkg::mem_req_t                  mem_req,
	output logic [ADDR_W-1:0]                   mem_addr,
	output cfrf_pkg::resp_t                     resp
);

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	logic [cfrf_pkg::ENABLE_W-1:0] enable_q;
	logic [IDX_W-1:0]              widx_q [CHANNELS];
	logic [IDX_W-1:0]              ridx_q [CHANNELS];
	logic                          full_q [CHANNELS];
	logic [cfrf_pkg::PEND_W-1:0]   pend_q [CHANNELS];

	logic [CH_W-1:0]             ch_idx;
	logic                        in_range;
	logic                        enabled;
	logic                        len_ok;
	logic [IDX_W-1:0]            widx, ridx, widx_nx, ridx_nx;
	logic                        full, full_nx;
	logic [cfrf_pkg::PEND_W-1:0] pend, pend_nx;
	logic                        push_ok, store, pop_hit;
	cfrf_pkg::status_t           status;

	assign ch_idx   = CH_W'(channel);
	assign in_range = 32'(channel) < CHANNELS;
	assign enabled  = 1'(enable_q >> channel);
	assign len_ok   = (frame_length != '0) && (frame_length <= cfrf_pkg::MAX_LEN);

	always_comb begin
		widx = '0;
		ridx = '0;
		full = 1'b0;
		pend = '0;
		if (in_range) begin
			widx = widx_q[ch_idx];
			ridx = ridx_q[ch_idx];
			full = full_q[ch_idx];
			pend = pend_q[ch_idx];
		end
	end

	always_comb begin
		push_ok = (kind == cfrf_pkg::KIND_PUSH) && in_range && enabled && len_ok;
		store   = push_ok && !full;
		pop_hit = (kind == cfrf_pkg::KIND_POP) && in_range && ((ridx != widx) || full);

		widx_nx = widx;
		ridx_nx = ridx;
		full_nx = full;
		pend_nx = pend;
		status  = cfrf_pkg::ST_IGNORED;

		if (kind == cfrf_pkg::KIND_PUSH) begin
			if (push_ok) begin
				if (pend != cfrf_pkg::PENDING_MAX) begin
					pend_nx = pend + 1'b1;
				end
				if (store) begin
					widx_nx = (widx == LAST_IDX) ? '0 : widx + 1'b1;
					full_nx = (widx_nx == ridx);
					status  = cfrf_pkg::ST_STORED;
				end else begin
					status = cfrf_pkg::ST_DROP_FULL;
				end
			end
		end else begin
			if (pop_hit) begin
				ridx_nx = (ridx == LAST_IDX) ? '0 : ridx + 1'b1;
				full_nx = 1'b0;
				if (pend != '0) begin
					pend_nx = pend - 1'b1;
				end
				status = cfrf_pkg::ST_POPPED;
			end else begin
				status = cfrf_pkg::ST_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				widx_q[c] <= '0;
				ridx_q[c] <= '0;
				full_q[c] <= 1'b0;
				pend_q[c] <= '0;
			end
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			if (accept && in_range) begin
				widx_q[ch_idx] <= widx_nx;
				ridx_q[ch_idx] <= ridx_nx;
				full_q[ch_idx] <= full_nx;
				pend_q[ch_idx] <= pend_nx;
			end
		end
	end

	// The slot is the write slot for a push and the read slot for a pop.
	assign mem_addr = ADDR_W'(ADDR_W'(ch_idx) * ADDR_W'(RING_DEPTH))
		+ ADDR_W'((kind == cfrf_pkg::KIND_POP) ? ridx : widx);

	assign mem_req.we = accept && store;
	assign mem_req.re = accept && pop_hit;

	assign resp.status  = status;
	assign resp.pending = pend_nx;
	assign resp.full    = full_nx;
	assign resp.hit     = pop_hit;

endmodule

>>> src/can_frame_receive_fifo_core.sv
// Top level of the CAN frame receive FIFO: handshakes, result stage and output register.
// One beat is accepted per cycle while the output side is not stalled; its result is
// registered in the result stage and then in the output register. Pointer state is
// read and updated in the accept cycle, and a pop reads the registered frame memory.
// Throughput is one beat per cycle while the output side is not stalled.
// Asynchronous active-low reset empties every ring and clears counts, flags and enables;
// the frame memory itself is not cleared, since only written slots are ever read.
module can_frame_receive_fifo_core #(
	parameter int CHANNELS   = 3,
	parameter int RING_DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cfrf_pkg::ENABLE_W-1:0]     cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [1:0]                        channel,
	input  logic [cfrf_pkg::ID_W-1:0]         frame_id,
	input  logic [cfrf_pkg::LEN_W-1:0]        frame_length,
	input  logic [cfrf_pkg::DATA_W-1:0]       frame_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic [cfrf_pkg::ID_W-1:0]         out_id,
	output logic [cfrf_pkg::LEN_W-1:0]        out_length,
	output logic [cfrf_pkg::DATA_W-1:0]       out_data,
	output logic [cfrf_pkg::PEND_W-1:0]       pending_count,
	output logic                              ring_full
);

	localparam int SLOTS  = CHANNELS * RING_DEPTH;
	localparam int ADDR_W = $clog2(SLOTS);

	logic               accept;
	logic               advance;
	cfrf_pkg::mem_req_t mem_req;
	logic [ADDR_W-1:0]  mem_addr;
	cfrf_pkg::resp_t    resp;
	cfrf_pkg::frame_t   wframe;
	cfrf_pkg::frame_t   rframe;

	logic               valid_s1;
	cfrf_pkg::resp_t    resp_s1;

	logic                          out_valid_q;
	cfrf_pkg::status_t             status_q;
	logic [cfrf_pkg::ID_W-1:0]     id_q;
	logic [cfrf_pkg::LEN_W-1:0]    len_q;
	logic [cfrf_pkg::DATA_W-1:0]   data_q;
	logic [cfrf_pkg::PEND_W-1:0]   pend_q;
	logic                          full_q;

	// The result stage moves on when the output register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	cfrf_ring_ctrl #(
		.CHANNELS   (CHANNELS),
		.RING_DEPTH (RING_DEPTH),
		.ADDR_W     (ADDR_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.kind         (kind),
		.channel      (channel),
		.frame_length (frame_length),
		.mem_req      (mem_req),
		.mem_addr     (mem_addr),
		.resp         (resp)
	);

	assign wframe.id   = frame_id;
	assign wframe.len  = frame_length;
	assign wframe.data = frame_data & cfrf_pkg::data_mask(frame_length);

	cfrf_frame_ram #(
		.DEPTH  (SLOTS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_addr),
		.wdata (wframe),
		.re    (mem_req.re),
		.raddr (mem_addr),
		.rdata (rframe)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			resp_s1 <= resp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= resp_s1.status;
			id_q     <= resp_s1.hit ? rframe.id : '0;
			len_q    <= resp_s1.hit ? rframe.len : '0;
			data_q   <= resp_s1.hit ? rframe.data : '0;
			pend_q   <= resp_s1.pending;
			full_q   <= resp_s1.full;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign out_id        = id_q;
	assign out_length    = len_q;
	assign out_data      = data_q;
	assign pending_count = pend_q;
	assign ring_full     = full_q;

endmodule

>>> src/cfrf_port_checker.sv
// Port-level checks of the CAN frame receive FIFO and their binding to the top level.
`include "can_frame_receive_fifo_core_macros.svh"

module cfrf_port_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [2:0]                        status,
	input logic [cfrf_pkg::ID_W-1:0]         out_id,
	input logic [cfrf_pkg::LEN_W-1:0]        out_length,
	input logic [cfrf_pkg::DATA_W-1:0]       out_data,
	input logic [cfrf_pkg::PEND_W-1:0]       pending_count,
	input logic                              ring_full
);

	`CFRF_ASSERT_RST(a_no_beat_in_reset, clk, !arst_n |-> !out_valid, "result beat during reset")

	`CFRF_ASSERT_CLK(a_stall_holds, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_data) && $stable(pending_count), "stalled result changed")

	`CFRF_ASSERT_CLK(a_zero_unless_pop, clk, arst_n, out_valid && (status != cfrf_pkg::ST_POPPED) |-> (out_id == '0) && (out_length == '0) && (out_data == '0), "frame fields set without a pop")

	`CFRF_ASSERT_CLK(a_pop_frame, clk, arst_n, out_valid && (status == cfrf_pkg::ST_POPPED) |-> !ring_full && (out_length != '0) && (out_length <= cfrf_pkg::MAX_LEN), "popped frame has bad length or ring still full")

	`CFRF_ASSERT_CLK(a_drop_full, clk, arst_n, out_valid && (status == cfrf_pkg::ST_DROP_FULL) |-> ring_full && (pending_count != '0), "frame dropped while ring not full")

endmodule

bind can_frame_receive_fifo_core cfrf_port_checker u_port_checker (.*);
